/* sv/ba_pkg.sv */
`default_nettype none
package ba_pkg;
	localparam int ARENA_ORDER  = 16;
	localparam int MIN_ORDER    = 5;
	localparam int HEADER_BYTES = 16;
	localparam int NUM_ORDERS   = 17;

	// granule index width and count
	localparam int GW       = ARENA_ORDER - MIN_ORDER;
	localparam int GRANULES = 1 << GW;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NOOP = 2'd1;
	localparam logic [1:0] ST_OOM  = 2'd2;
	localparam logic [1:0] ST_BAD  = 2'd3;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// one granule entry: head mark, free flag, block order
	typedef struct packed {
		logic       head;
		logic       free;
		logic [4:0] ord;
	} entry_t;
endpackage
`default_nettype wire

/* sv/buddy_allocator.sv */
`default_nettype none
// Binary buddy allocator over a 2^ARENA_ORDER byte arena in 2^MIN_ORDER granules.
// Input channel (in_valid/in_ready) takes one word: command, request_bytes,
// release_address. Output channel (out_valid/out_ready) returns one word per
// input: data_address and status.
// Allocate: size the request one order at a time, then read and check each block
// walked from address zero, then split the chosen block one level at a time and
// mark what is left taken. Free: read and check the block, then for each merge
// level read and check the buddy, clear the upper entry and write the merged block.
// Every table access goes through the single port of the block table memory. A
// no-op or a malformed free is answered from the idle state, without a table access.
// One word is worked at a time; in_ready is low while busy or while a result
// is held. A stalled receiver holds the result in the output register and the
// block takes no new word until it is taken.
// After reset the table is swept one entry a cycle (all GRANULES entries, 2048 by
// default) to one free block spanning the arena; in_ready stays low meanwhile.
module buddy_allocator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command,
	input  wire logic [16:0] request_bytes,
	input  wire logic [15:0] release_address,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      data_address,
	output logic [1:0]       status
);
	localparam int GW = ba_pkg::GW;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_NEED, S_SCAN_RD, S_SCAN_EV, S_SPLIT,
		S_FREE_RD, S_FREE_EV, S_MERGE_RD, S_MERGE_EV, S_MERGE_WR
	} state_t;

	state_t state_q;
	logic [GW-1:0]   clr_q;
	logic [17:0]     total_q;
	logic [4:0]      need_q;
	logic [GW:0]     g_q;
	logic [GW-1:0]   best_q;
	logic [4:0]      ord_q;
	logic            found_q;
	logic            out_valid_q;
	logic [15:0]     data_address_q;
	logic [1:0]      status_q;

	// block table memory, one port
	ba_pkg::entry_t mem [ba_pkg::GRANULES];
	ba_pkg::entry_t rdata_q;
	ba_pkg::entry_t wdata;
	logic [GW-1:0]  mem_addr;
	logic           mem_we;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= wdata;
		rdata_q <= mem[mem_addr];
	end

	// free request checks on the input word
	logic [15:0] off;
	logic        free_bad;
	logic [31:0] off_w;
	assign off   = release_address - 16'(ba_pkg::HEADER_BYTES);
	assign off_w = 32'(off);
	assign free_bad = (32'(release_address) < 32'(ba_pkg::HEADER_BYTES)) ||
		(off_w >= (32'd1 << ba_pkg::ARENA_ORDER)) ||
		(off[ba_pkg::MIN_ORDER-1:0] != '0);

	// scan entry decode
	logic [4:0]  scan_ord;
	logic [GW:0] span;
	logic        cand;
	always_comb begin
		scan_ord = rdata_q.ord;
		if (rdata_q.ord < 5'(ba_pkg::MIN_ORDER) || rdata_q.ord > 5'(ba_pkg::ARENA_ORDER) ||
				!rdata_q.head)
			scan_ord = 5'(ba_pkg::MIN_ORDER);
		span = (GW+1)'(1) << (scan_ord - 5'(ba_pkg::MIN_ORDER));
		cand = rdata_q.head && rdata_q.free && (scan_ord >= need_q) &&
			(!found_q || scan_ord < ord_q);
	end

	// split and merge offsets
	logic [GW-1:0] half_bit, bud_bit, upper, bg;
	logic [31:0]   grant_addr;
	logic          buddy_ok;
	assign half_bit = GW'(1) << (ord_q - 5'(ba_pkg::MIN_ORDER) - 5'd1);
	assign bud_bit  = GW'(1) << (ord_q - 5'(ba_pkg::MIN_ORDER));
	assign upper    = best_q + half_bit;
	assign bg       = g_q[GW-1:0] ^ bud_bit;
	assign grant_addr = (32'(best_q) << ba_pkg::MIN_ORDER) + 32'(ba_pkg::HEADER_BYTES);
	assign buddy_ok = rdata_q.head && rdata_q.free && (rdata_q.ord == ord_q);

	// memory port selection
	always_comb begin
		mem_addr = g_q[GW-1:0];
		mem_we   = 1'b0;
		wdata    = '0;
		case (state_q)
			S_CLEAR: begin
				mem_addr = clr_q;
				mem_we   = 1'b1;
				if (clr_q == '0)
					wdata = '{head: 1'b1, free: 1'b1, ord: 5'(ba_pkg::ARENA_ORDER)};
			end
			S_SPLIT: begin
				mem_we = 1'b1;
				if (ord_q > need_q) begin
					mem_addr = upper;
					wdata    = '{head: 1'b1, free: 1'b1, ord: ord_q - 5'd1};
				end else begin
					mem_addr = best_q;
					wdata    = '{head: 1'b1, free: 1'b0, ord: ord_q};
				end
			end
			S_FREE_EV: begin
				mem_we = rdata_q.head && !rdata_q.free &&
					rdata_q.ord >= 5'(ba_pkg::MIN_ORDER) &&
					rdata_q.ord <= 5'(ba_pkg::ARENA_ORDER);
				wdata  = '{head: 1'b1, free: 1'b1, ord: rdata_q.ord};
			end
			S_MERGE_RD: mem_addr = bg;
			S_MERGE_EV: begin
				mem_addr = g_q[GW-1:0] | bud_bit;
				mem_we   = buddy_ok;
			end
			S_MERGE_WR: begin
				mem_we = 1'b1;
				wdata  = '{head: 1'b1, free: 1'b1, ord: ord_q};
			end
			default: ;
		endcase
	end

	assign in_ready     = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid    = out_valid_q;
	assign data_address = data_address_q;
	assign status       = status_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			out_valid_q    <= 1'b0;
			found_q        <= 1'b0;
			total_q        <= '0;
			need_q         <= '0;
			g_q            <= '0;
			best_q         <= '0;
			ord_q          <= '0;
			data_address_q <= '0;
			status_q       <= ba_pkg::ST_OK;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + GW'(1);
					if (clr_q == '1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid && in_ready) begin
						data_address_q <= '0;
						if (command == ba_pkg::CMD_ALLOC) begin
							if (request_bytes == '0) begin
								status_q    <= ba_pkg::ST_NOOP;
								out_valid_q <= 1'b1;
							end else begin
								total_q <= 18'(request_bytes) + 18'(ba_pkg::HEADER_BYTES);
								need_q  <= 5'(ba_pkg::MIN_ORDER);
								state_q <= S_NEED;
							end
						end else if (release_address == '0) begin
							status_q    <= ba_pkg::ST_NOOP;
							out_valid_q <= 1'b1;
						end else if (free_bad) begin
							status_q    <= ba_pkg::ST_BAD;
							out_valid_q <= 1'b1;
						end else begin
							g_q     <= (GW+1)'(off_w >> ba_pkg::MIN_ORDER);
							state_q <= S_FREE_RD;
						end
					end
				end
				S_NEED: begin
					if ((19'd1 << need_q) < 19'(total_q)) begin
						need_q <= need_q + 5'd1;
					end else if (need_q > 5'(ba_pkg::ARENA_ORDER) ||
							need_q >= 5'(ba_pkg::NUM_ORDERS)) begin
						status_q    <= ba_pkg::ST_OOM;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						g_q     <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_EV;
				S_SCAN_EV: begin
					if (cand) begin
						found_q <= 1'b1;
						best_q  <= g_q[GW-1:0];
						ord_q   <= scan_ord;
					end
					if (32'(g_q) + 32'(span) >= 32'(ba_pkg::GRANULES)) begin
						if (cand || found_q) begin
							state_q <= S_SPLIT;
						end else begin
							status_q    <= ba_pkg::ST_OOM;
							out_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end
					end else begin
						g_q     <= g_q + span;
						state_q <= S_SCAN_RD;
					end
				end
				S_SPLIT: begin
					if (ord_q > need_q) begin
						ord_q <= ord_q - 5'd1;
					end else begin
						data_address_q <= grant_addr[15:0];
						status_q       <= ba_pkg::ST_OK;
						out_valid_q    <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				S_FREE_RD: state_q <= S_FREE_EV;
				S_FREE_EV: begin
					if (mem_we) begin
						ord_q   <= rdata_q.ord;
						state_q <= S_MERGE_RD;
					end else begin
						status_q    <= ba_pkg::ST_BAD;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_MERGE_RD: begin
					if (ord_q >= 5'(ba_pkg::ARENA_ORDER)) begin
						status_q    <= ba_pkg::ST_OK;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_MERGE_EV;
					end
				end
				S_MERGE_EV: begin
					if (buddy_ok) begin
						g_q     <= {1'b0, g_q[GW-1:0] & ~bud_bit};
						ord_q   <= ord_q + 5'd1;
						state_q <= S_MERGE_WR;
					end else begin
						status_q    <= ba_pkg::ST_OK;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_MERGE_WR: state_q <= S_MERGE_RD;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* sv/buddy_allocator_checker.sv */
`default_nettype none
module buddy_allocator_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] data_address,
	input wire logic [1:0]  status
);
	// held result word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_address) && $stable(status))
		else $error("result word changed while stalled");

	// only a granted block carries an address
	a_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ba_pkg::ST_OK |-> data_address == '0)
		else $error("address on a failed result");

	// one word in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while busy");

	// no new word while a result is held
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("ready while result pending");
endmodule

bind buddy_allocator buddy_allocator_checker u_checker (.*);
`default_nettype wire

/* tb/buddy_allocator_tb.sv */
module buddy_allocator_tb;
	localparam int WATCHDOG = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [16:0] request_bytes;
	logic [15:0] release_address;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] data_address;
	logic [1:0]  status;

	buddy_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .request_bytes(request_bytes),
		.release_address(release_address),
		.out_valid(out_valid), .out_ready(out_ready),
		.data_address(data_address), .status(status)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// shadow of the allocator tables
	logic       shadow_head [ba_pkg::GRANULES];
	logic       shadow_free [ba_pkg::GRANULES];
	logic [4:0] shadow_ord  [ba_pkg::GRANULES];

	// addresses handed out; a freed one sometimes stays to force a double free
	logic [15:0] held_addrs[$];

	// expected result words, oldest first
	logic [15:0] want_addr[$];
	logic [1:0]  want_status[$];

	int mismatches;
	int idle_cycles;

	function automatic void shadow_reset();
		for (int i = 0; i < ba_pkg::GRANULES; i++) begin
			shadow_head[i] = 1'b0;
			shadow_free[i] = 1'b0;
			shadow_ord[i] = '0;
		end
		shadow_head[0] = 1'b1;
		shadow_free[0] = 1'b1;
		shadow_ord[0] = 5'(ba_pkg::ARENA_ORDER);
	endfunction

	// allocate: smallest free block (lowest address among equals), split down
	function automatic void shadow_alloc(input logic [16:0] nbytes,
			output logic [15:0] addr, output logic [1:0] st);
		longint total;
		int need, g, o, best, best_o;
		bit found;
		total = longint'(nbytes) + ba_pkg::HEADER_BYTES;
		need = ba_pkg::MIN_ORDER;
		best = 0;
		best_o = 0;
		found = 0;
		addr = '0;
		while (need < 40 && (longint'(1) << need) < total) need++;
		if (need > ba_pkg::ARENA_ORDER || need >= ba_pkg::NUM_ORDERS) begin
			st = ba_pkg::ST_OOM;
			return;
		end
		g = 0;
		while (g < ba_pkg::GRANULES) begin
			o = shadow_ord[g];
			if (o < ba_pkg::MIN_ORDER || o > ba_pkg::ARENA_ORDER || !shadow_head[g])
				o = ba_pkg::MIN_ORDER;
			if (shadow_head[g] && shadow_free[g] && o >= need && (!found || o < best_o)) begin
				found = 1;
				best = g;
				best_o = o;
			end
			g += 1 << (o - ba_pkg::MIN_ORDER);
		end
		if (!found) begin
			st = ba_pkg::ST_OOM;
			return;
		end
		while (best_o > need) begin
			best_o--;
			g = best + (1 << (best_o - ba_pkg::MIN_ORDER));
			shadow_head[g] = 1'b1;
			shadow_free[g] = 1'b1;
			shadow_ord[g] = 5'(best_o);
		end
		shadow_free[best] = 1'b0;
		shadow_ord[best] = 5'(best_o);
		addr = 16'((best << ba_pkg::MIN_ORDER) + ba_pkg::HEADER_BYTES);
		st = ba_pkg::ST_OK;
	endfunction

	// free: validate, mark free, merge with buddies
	function automatic logic [1:0] shadow_release(input logic [15:0] addr);
		int off, g, o, bg, lo;
		if (addr == 0) return ba_pkg::ST_NOOP;
		if (addr < ba_pkg::HEADER_BYTES) return ba_pkg::ST_BAD;
		off = int'(addr) - ba_pkg::HEADER_BYTES;
		if (off >= (1 << ba_pkg::ARENA_ORDER) || (off & ((1 << ba_pkg::MIN_ORDER) - 1)) != 0)
			return ba_pkg::ST_BAD;
		g = off >> ba_pkg::MIN_ORDER;
		if (!shadow_head[g] || shadow_free[g]) return ba_pkg::ST_BAD;
		o = shadow_ord[g];
		if (o < ba_pkg::MIN_ORDER || o > ba_pkg::ARENA_ORDER) return ba_pkg::ST_BAD;
		shadow_free[g] = 1'b1;
		while (o < ba_pkg::ARENA_ORDER) begin
			bg = g ^ (1 << (o - ba_pkg::MIN_ORDER));
			if (bg >= ba_pkg::GRANULES || !shadow_head[bg] || !shadow_free[bg]
					|| shadow_ord[bg] != 5'(o))
				break;
			lo = g < bg ? g : bg;
			bg = g < bg ? bg : g;
			shadow_head[bg] = 1'b0;
			shadow_free[bg] = 1'b0;
			shadow_ord[bg] = '0;
			g = lo;
			o++;
			shadow_ord[g] = 5'(o);
		end
		return ba_pkg::ST_OK;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// send one word, record its expected result; fixed checks use the typed value
	task automatic send_word(input logic cmd, input logic [16:0] nbytes,
			input logic [15:0] addr, input bit fixed, input logic [15:0] fix_addr,
			input logic [1:0] fix_st);
		logic [15:0] got_addr;
		logic [1:0]  got_st;
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		request_bytes <= nbytes;
		release_address <= addr;
		do @(posedge clk); while (!in_ready);
		if (cmd == ba_pkg::CMD_ALLOC) begin
			if (nbytes == 0) begin
				got_addr = '0;
				got_st = ba_pkg::ST_NOOP;
			end else begin
				shadow_alloc(nbytes, got_addr, got_st);
			end
			if (got_st == ba_pkg::ST_OK && got_addr != 0) held_addrs.push_back(got_addr);
		end else begin
			got_addr = '0;
			got_st = shadow_release(addr);
		end
		if (fixed) begin
			got_addr = fix_addr;
			got_st = fix_st;
		end
		want_addr.push_back(got_addr);
		want_status.push_back(got_st);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (want_addr.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: addr %h status %0d", data_address, status);
			end else begin
				if (data_address !== want_addr[0] || status !== want_status[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want addr %h status %0d, got addr %h status %0d",
							want_addr[0], want_status[0], data_address, status);
				end
				void'(want_addr.pop_front());
				void'(want_status.pop_front());
			end
		end
	end

	// receiver stalls
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 3) == 0) out_ready <= 1'b1;
			else out_ready <= (pick_gap() == 0);
		end
	end

	// watchdog: cycles without any accepted word
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG + ba_pkg::GRANULES) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	typedef struct {
		logic        cmd;
		logic [16:0] nbytes;
		logic [15:0] addr;
		bit          fixed;
		logic [15:0] fix_addr;
		logic [1:0]  fix_st;
	} stim_row_t;

	stim_row_t directed[] = '{
		'{ba_pkg::CMD_ALLOC, 17'd0,     16'd0,    1, 16'h0000, ba_pkg::ST_NOOP},
		'{ba_pkg::CMD_FREE,  17'd0,     16'd0,    1, 16'h0000, ba_pkg::ST_NOOP},
		'{ba_pkg::CMD_FREE,  17'd0,     16'd8,    1, 16'h0000, ba_pkg::ST_BAD},
		'{ba_pkg::CMD_FREE,  17'd0,     16'd15,   1, 16'h0000, ba_pkg::ST_BAD},
		'{ba_pkg::CMD_FREE,  17'd0,     16'd16,   1, 16'h0000, ba_pkg::ST_BAD},
		'{ba_pkg::CMD_FREE,  17'd0,     16'd17,   1, 16'h0000, ba_pkg::ST_BAD},
		'{ba_pkg::CMD_FREE,  17'd0,     16'hFFFF, 1, 16'h0000, ba_pkg::ST_BAD},
		'{ba_pkg::CMD_ALLOC, 17'h1FFFF, 16'hFFFF, 1, 16'h0000, ba_pkg::ST_OOM},
		'{ba_pkg::CMD_ALLOC, 17'd65536, 16'd0,    1, 16'h0000, ba_pkg::ST_OOM},
		'{ba_pkg::CMD_ALLOC, 17'd65521, 16'd0,    1, 16'h0000, ba_pkg::ST_OOM},
		'{ba_pkg::CMD_ALLOC, 17'd65520, 16'd0,    1, 16'h0010, ba_pkg::ST_OK},
		'{ba_pkg::CMD_ALLOC, 17'd1,     16'd0,    1, 16'h0000, ba_pkg::ST_OOM},
		'{ba_pkg::CMD_FREE,  17'd0,     16'h0010, 1, 16'h0000, ba_pkg::ST_OK},
		'{ba_pkg::CMD_FREE,  17'd0,     16'h0010, 1, 16'h0000, ba_pkg::ST_BAD},
		'{ba_pkg::CMD_ALLOC, 17'd1,     16'd0,    1, 16'h0010, ba_pkg::ST_OK},
		'{ba_pkg::CMD_ALLOC, 17'd16,    16'd0,    0, 16'h0000, ba_pkg::ST_OK},
		'{ba_pkg::CMD_ALLOC, 17'd17,    16'd0,    0, 16'h0000, ba_pkg::ST_OK},
		'{ba_pkg::CMD_ALLOC, 17'd1000,  16'd0,    0, 16'h0000, ba_pkg::ST_OK},
		'{ba_pkg::CMD_FREE,  17'd0,     16'h0030, 0, 16'h0000, ba_pkg::ST_OK},
		'{ba_pkg::CMD_FREE,  17'd0,     16'h0050, 0, 16'h0000, ba_pkg::ST_OK},
		'{ba_pkg::CMD_FREE,  17'd0,     16'h0010, 0, 16'h0000, ba_pkg::ST_OK},
		'{ba_pkg::CMD_ALLOC, 17'd30000, 16'd0,    0, 16'h0000, ba_pkg::ST_OK}
	};

	// stimulus
	initial begin
		logic        cmd;
		logic [16:0] nbytes;
		logic [15:0] addr;
		int r, idx, drain;
		mismatches = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = 1'b0;
		request_bytes = '0;
		release_address = '0;
		shadow_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_word(directed[i].cmd, directed[i].nbytes, directed[i].addr,
				directed[i].fixed, directed[i].fix_addr, directed[i].fix_st);

		for (int n = 0; n < 700; n++) begin
			r = $urandom_range(0, 99);
			nbytes = '0;
			addr = '0;
			if (r < 45) begin
				// mostly small sizes, a few large, rare raw noise
				cmd = ba_pkg::CMD_ALLOC;
				case ($urandom_range(0, 9))
					0:       nbytes = 17'($urandom);
					1:       nbytes = 17'($urandom_range(4096, 65536));
					default: nbytes = 17'($urandom_range(1, 400));
				endcase
			end else if (r < 85 && held_addrs.size() > 0) begin
				// release a held block; sometimes keep it to force a double free
				cmd = ba_pkg::CMD_FREE;
				idx = $urandom_range(0, held_addrs.size() - 1);
				addr = held_addrs[idx];
				if ($urandom_range(0, 7) != 0) held_addrs.delete(idx);
			end else begin
				cmd = 1'($urandom);
				nbytes = 17'($urandom);
				addr = 16'($urandom);
				if ($urandom_range(0, 1)) addr = {addr[15:5], 5'h10};
			end
			send_word(cmd, nbytes, addr, 0, '0, ba_pkg::ST_OK);
		end
		in_valid <= 1'b0;

		drain = 0;
		while (want_addr.size() != 0 && drain < 200000) begin
			@(posedge clk);
			drain++;
		end
		repeat (100) @(posedge clk);
		if (mismatches == 0 && want_addr.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

/* filelist.f */
sv/ba_pkg.sv
sv/buddy_allocator.sv
sv/buddy_allocator_checker.sv
tb/buddy_allocator_tb.sv
